>>> rtl/ppi_pkg.sv
// Package for the phrase position intersect block: sizes, command and status
// codes, sequencer states, item structs and memory request structs.
// No dependencies.
`default_nettype none

package ppi_pkg;

  // Sizes
  localparam int MAX_TERMS   = 8;
  localparam int LIST_DEPTH  = 256;
  localparam int MATCH_DEPTH = 256;

  localparam int TERM_W   = $clog2(MAX_TERMS);
  localparam int KW       = TERM_W + 1;
  localparam int LIST_AW  = $clog2(LIST_DEPTH);
  localparam int LCNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int MATCH_AW = $clog2(MATCH_DEPTH);
  localparam int MCNT_W   = $clog2(MATCH_DEPTH + 1);
  localparam int POS_AW   = TERM_W + LIST_AW;
  localparam int DATA_W   = 32;

  // Reset value of the term count register
  localparam logic [3:0] TERM_COUNT_RST = 4'd2;

  // Command codes
  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_OFFSET = 3'd2,
    CMD_RUN    = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_SK_RD,
    S_SK_CHK,
    S_DECIDE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  term;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  match_count;
    logic [31:0] read_value;
  } out_item_t;

  // Position memory request
  typedef struct packed {
    logic              we;
    logic [POS_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [POS_AW-1:0] raddr;
  } pos_req_t;

  // Match memory request
  typedef struct packed {
    logic                we;
    logic [MATCH_AW-1:0] waddr;
    logic [DATA_W-1:0]   wdata;
    logic                re;
    logic [MATCH_AW-1:0] raddr;
  } match_req_t;

endpackage

`default_nettype wire

>>> rtl/phrase_position_intersect.sv
// Phrase search over term position lists. Clear, append and set-offset items
// can follow each other without a gap; their result shows the next cycle. A
// read goes through the match memory's registered read and the S_RDWAIT
// state. A run holds busy while it walks the lists: each cursor step is a
// position memory read (S_SK_RD), then the compare (S_SK_CHK), each
// candidate start passes through S_DECIDE, and S_DONE finishes the run.
// Results come out on out_valid for one cycle and cannot be stalled by the
// receiver. The term count register is written through cfg_* while the block
// is idle.
// Depends on ppi_pkg, ppi_ram and ppi_ctrl.
`default_nettype none

module phrase_position_intersect (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ppi_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output ppi_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_data
);

  localparam int KW = ppi_pkg::KW;

  logic [3:0]             term_count_r;
  logic [KW-1:0]          run_terms;
  ppi_pkg::pos_req_t      pos_req;
  ppi_pkg::match_req_t    match_req;
  logic [ppi_pkg::DATA_W-1:0] pos_rdata;
  logic [ppi_pkg::DATA_W-1:0] match_rdata;

  // Term count register
  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= ppi_pkg::TERM_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      term_count_r <= cfg_data;
    end
  end

  // Clamp term count into 1..MAX_TERMS
  always_comb begin
    priority if (term_count_r == 4'd0) begin
      run_terms = KW'(1);
    end else if (32'(term_count_r) > ppi_pkg::MAX_TERMS) begin
      run_terms = KW'(ppi_pkg::MAX_TERMS);
    end else begin
      run_terms = KW'(term_count_r);
    end
  end

  ppi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_item     (in_item),
    .busy        (busy),
    .run_terms   (run_terms),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .pos_req     (pos_req),
    .pos_rdata   (pos_rdata),
    .match_req   (match_req),
    .match_rdata (match_rdata)
  );

  // Position lists, one row of LIST_DEPTH entries per term
  ppi_ram #(
    .AW (ppi_pkg::POS_AW),
    .DW (ppi_pkg::DATA_W)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_req.we),
    .waddr (pos_req.waddr),
    .wdata (pos_req.wdata),
    .re    (pos_req.re),
    .raddr (pos_req.raddr),
    .rdata (pos_rdata)
  );

  // Match store
  ppi_ram #(
    .AW (ppi_pkg::MATCH_AW),
    .DW (ppi_pkg::DATA_W)
  ) u_match_ram (
    .clk   (clk),
    .we    (match_req.we),
    .waddr (match_req.waddr),
    .wdata (match_req.wdata),
    .re    (match_req.re),
    .raddr (match_req.raddr),
    .rdata (match_rdata)
  );

`ifndef SYNTHESIS
  // A run item taken while idle always raises busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.command == ppi_pkg::CMD_RUN)) |=> busy)
    else $error("run item did not raise busy");

  // Leaving a busy phase always delivers the item's result
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A rejected read returns zero data
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ppi_pkg::ST_BAD_INDEX)) |-> (out_item.read_value == '0))
    else $error("bad read index returned data");

  // Match count never exceeds the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.match_count) <= ppi_pkg::MATCH_DEPTH))
    else $error("match count beyond store depth");
`endif

endmodule

`default_nettype wire

>>> rtl/ppi_ram.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// No dependencies.
`default_nettype none

module ppi_ram #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/ppi_ctrl.sv
// Command decode and search sequencer: list lengths, term offsets, cursors,
// match count, and the request side of the position and match memories.
// Depends on ppi_pkg.
`default_nettype none

module ppi_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire ppi_pkg::in_item_t       in_item,
  output logic                         busy,
  input  wire logic [ppi_pkg::KW-1:0]  run_terms,
  output logic                         out_valid,
  output ppi_pkg::out_item_t           out_item,
  output ppi_pkg::pos_req_t            pos_req,
  input  wire logic [ppi_pkg::DATA_W-1:0] pos_rdata,
  output ppi_pkg::match_req_t          match_req,
  input  wire logic [ppi_pkg::DATA_W-1:0] match_rdata
);

  localparam int TERM_W   = ppi_pkg::TERM_W;
  localparam int KW       = ppi_pkg::KW;
  localparam int LIST_AW  = ppi_pkg::LIST_AW;
  localparam int LCNT_W   = ppi_pkg::LCNT_W;
  localparam int MATCH_AW = ppi_pkg::MATCH_AW;
  localparam int MCNT_W   = ppi_pkg::MCNT_W;
  localparam int DATA_W   = ppi_pkg::DATA_W;
  localparam int NT       = ppi_pkg::MAX_TERMS;

  ppi_pkg::state_e    state_r, state_nxt;
  logic [LCNT_W-1:0]  len_r [NT];
  logic [LCNT_W-1:0]  len_nxt [NT];
  logic [DATA_W-1:0]  off_r [NT];
  logic [DATA_W-1:0]  off_nxt [NT];
  logic [LCNT_W-1:0]  cur_r [NT];
  logic [LCNT_W-1:0]  cur_nxt [NT];
  logic [MCNT_W-1:0]  found_r, found_nxt;
  logic [TERM_W-1:0]  t_r, t_nxt;
  logic [DATA_W-1:0]  floor_r, floor_nxt;
  logic [DATA_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0]  next_r, next_nxt;
  logic               ahead_r, ahead_nxt;
  logic               dropped_r, dropped_nxt;
  logic               out_valid_r, out_valid_nxt;
  ppi_pkg::out_item_t out_item_r, out_item_nxt;

  // Current term's cursor, length and offset
  logic [LCNT_W-1:0] cur_t;
  logic [LCNT_W-1:0] len_t;
  logic [DATA_W-1:0] off_t;
  logic [DATA_W-1:0] aligned;
  logic              hit;
  logic              last_term;
  logic              read_ok;

  assign cur_t     = cur_r[t_r];
  assign len_t     = len_r[t_r];
  assign off_t     = off_r[t_r];
  assign aligned   = pos_rdata - off_t;
  // Entry counts when it has an aligned value at or above the floor
  assign hit       = (pos_rdata >= off_t) && (aligned >= floor_r);
  assign last_term = (KW'(t_r) == (run_terms - KW'(1)));
  assign read_ok   = (in_item.value < DATA_W'(found_r)) &&
                     (in_item.value < DATA_W'(ppi_pkg::MATCH_DEPTH));

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    off_nxt       = off_r;
    cur_nxt       = cur_r;
    found_nxt     = found_r;
    t_nxt         = t_r;
    floor_nxt     = floor_r;
    pos_nxt       = pos_r;
    next_nxt      = next_r;
    ahead_nxt     = ahead_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pos_req       = '0;
    match_req     = '0;

    unique case (state_r)
      ppi_pkg::S_IDLE: begin
        if (start) begin
          out_item_nxt.status      = ppi_pkg::ST_OK;
          out_item_nxt.match_count = 9'(found_r);
          out_item_nxt.read_value  = '0;
          out_valid_nxt            = 1'b1;
          unique case (ppi_pkg::cmd_e'(in_item.command))
            ppi_pkg::CMD_CLEAR: begin
              for (int j = 0; j < NT; j++) begin
                len_nxt[j] = '0;
                off_nxt[j] = '0;
              end
              found_nxt                = '0;
              out_item_nxt.match_count = '0;
            end
            ppi_pkg::CMD_APPEND: begin
              if (len_r[in_item.term] >= LCNT_W'(ppi_pkg::LIST_DEPTH)) begin
                out_item_nxt.status = ppi_pkg::ST_FULL;
              end else begin
                pos_req.we            = 1'b1;
                pos_req.waddr         = {in_item.term, len_r[in_item.term][LIST_AW-1:0]};
                pos_req.wdata         = in_item.value;
                len_nxt[in_item.term] = len_r[in_item.term] + LCNT_W'(1);
              end
            end
            ppi_pkg::CMD_OFFSET: begin
              off_nxt[in_item.term] = in_item.value;
            end
            ppi_pkg::CMD_RUN: begin
              for (int j = 0; j < NT; j++) begin
                cur_nxt[j] = '0;
              end
              found_nxt     = '0;
              dropped_nxt   = 1'b0;
              t_nxt         = '0;
              floor_nxt     = '0;
              out_valid_nxt = 1'b0;
              state_nxt     = ppi_pkg::S_SK_RD;
            end
            ppi_pkg::CMD_READ: begin
              if (read_ok) begin
                match_req.re  = 1'b1;
                match_req.raddr = in_item.value[MATCH_AW-1:0];
                out_valid_nxt = 1'b0;
                state_nxt     = ppi_pkg::S_RDWAIT;
              end else begin
                out_item_nxt.status = ppi_pkg::ST_BAD_INDEX;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Match data arrives from the memory
      ppi_pkg::S_RDWAIT: begin
        out_item_nxt.status      = ppi_pkg::ST_OK;
        out_item_nxt.match_count = 9'(found_r);
        out_item_nxt.read_value  = match_rdata;
        out_valid_nxt            = 1'b1;
        state_nxt                = ppi_pkg::S_IDLE;
      end

      // Fetch the entry under the current term's cursor; an exhausted list ends the run
      ppi_pkg::S_SK_RD: begin
        if (cur_t >= len_t) begin
          state_nxt = ppi_pkg::S_DONE;
        end else begin
          pos_req.re    = 1'b1;
          pos_req.raddr = {t_r, cur_t[LIST_AW-1:0]};
          state_nxt     = ppi_pkg::S_SK_CHK;
        end
      end

      // Check the fetched entry against the floor
      ppi_pkg::S_SK_CHK: begin
        if (!hit) begin
          cur_nxt[t_r] = cur_t + LCNT_W'(1);
          state_nxt    = ppi_pkg::S_SK_RD;
        end else if (t_r == '0) begin
          // New candidate start from the first term
          pos_nxt   = aligned;
          ahead_nxt = 1'b0;
          if (run_terms == KW'(1)) begin
            state_nxt = ppi_pkg::S_DECIDE;
          end else begin
            t_nxt     = TERM_W'(1);
            floor_nxt = aligned;
            state_nxt = ppi_pkg::S_SK_RD;
          end
        end else begin
          // Track the largest aligned value past the candidate
          if ((aligned > pos_r) && (!ahead_r || (aligned > next_r))) begin
            next_nxt  = aligned;
            ahead_nxt = 1'b1;
          end
          if (last_term) begin
            state_nxt = ppi_pkg::S_DECIDE;
          end else begin
            t_nxt     = t_r + TERM_W'(1);
            state_nxt = ppi_pkg::S_SK_RD;
          end
        end
      end

      // Leapfrog the first term, or record the match and step past it
      ppi_pkg::S_DECIDE: begin
        t_nxt     = '0;
        state_nxt = ppi_pkg::S_SK_RD;
        if (ahead_r) begin
          floor_nxt = next_r;
        end else begin
          if (found_r < MCNT_W'(ppi_pkg::MATCH_DEPTH)) begin
            match_req.we    = 1'b1;
            match_req.waddr = found_r[MATCH_AW-1:0];
            match_req.wdata = pos_r;
            found_nxt       = found_r + MCNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          cur_nxt[0] = cur_r[0] + LCNT_W'(1);
          floor_nxt  = '0;
        end
      end

      ppi_pkg::S_DONE: begin
        out_item_nxt.status      = dropped_r ? ppi_pkg::ST_FULL : ppi_pkg::ST_OK;
        out_item_nxt.match_count = 9'(found_r);
        out_item_nxt.read_value  = '0;
        out_valid_nxt            = 1'b1;
        state_nxt                = ppi_pkg::S_IDLE;
      end

      default: begin
        state_nxt = ppi_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppi_pkg::S_IDLE;
      found_r     <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < NT; j++) begin
        len_r[j] <= '0;
        off_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      off_r       <= off_nxt;
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    t_r        <= t_nxt;
    floor_r    <= floor_nxt;
    pos_r      <= pos_nxt;
    next_r     <= next_nxt;
    ahead_r    <= ahead_nxt;
    dropped_r  <= dropped_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ppi_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for phrase_position_intersect: directed items, then random
// phrase loads, runs and reads, checked by a built-in predictor or fixed results.
// Depends on ppi_pkg and the phrase_position_intersect RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ppi_pkg::*;

  // Command codes the block leaves unused
  localparam logic [2:0] CMD_RSVD_A = 3'd5;
  localparam logic [2:0] CMD_RSVD_B = 3'd6;
  localparam logic [2:0] CMD_RSVD_C = 3'd7;

  // One row of the directed table; fixed rows carry a hand-written result
  typedef struct packed {
    in_item_t  item;
    logic      fixed;
    out_item_t fixed_result;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  // Predictor state
  logic [31:0] pos_list [MAX_TERMS][LIST_DEPTH];
  int unsigned list_len [MAX_TERMS];
  logic [31:0] term_off [MAX_TERMS];
  logic [31:0] found_starts [MATCH_DEPTH];
  int unsigned found_cnt;
  logic [3:0]  term_cnt_reg;

  out_item_t   pending_results [$];
  out_item_t   oldest_result;
  int          mismatches = 0;
  int          items_sent = 0;
  int          idle_pct = 0;

  dir_row_t dir_rows [26] = '{
    '{'{CMD_READ,   3'd0, 32'd0},          1'b1, '{ST_BAD_INDEX, 9'd0, 32'd0}},
    '{'{CMD_READ,   3'd5, 32'hFFFF_FFFF},  1'b1, '{ST_BAD_INDEX, 9'd0, 32'd0}},
    '{'{CMD_RUN,    3'd0, 32'd0},          1'b1, '{ST_OK, 9'd0, 32'd0}},
    '{'{CMD_APPEND, 3'd0, 32'd0},          1'b1, '{ST_OK, 9'd0, 32'd0}},
    '{'{CMD_APPEND, 3'd0, 32'd7},          1'b1, '{ST_OK, 9'd0, 32'd0}},
    '{'{CMD_APPEND, 3'd0, 32'hFFFF_FFFF},  1'b1, '{ST_OK, 9'd0, 32'd0}},
    '{'{CMD_OFFSET, 3'd1, 32'd3},          1'b1, '{ST_OK, 9'd0, 32'd0}},
    // below its offset: no aligned value, skipped by the run
    '{'{CMD_APPEND, 3'd1, 32'd1},          1'b0, '0},
    '{'{CMD_APPEND, 3'd1, 32'd3},          1'b0, '0},
    '{'{CMD_APPEND, 3'd1, 32'd10},         1'b0, '0},
    '{'{CMD_APPEND, 3'd1, 32'hFFFF_FFFF},  1'b0, '0},
    // term 7 is loaded but inactive with two terms
    '{'{CMD_OFFSET, 3'd7, 32'hFFFF_FFFF},  1'b0, '0},
    '{'{CMD_APPEND, 3'd7, 32'hFFFF_FFFF},  1'b0, '0},
    '{'{CMD_RUN,    3'd0, 32'd0},          1'b0, '0},
    '{'{CMD_READ,   3'd0, 32'd0},          1'b0, '0},
    '{'{CMD_READ,   3'd0, 32'd1},          1'b0, '0},
    '{'{CMD_READ,   3'd0, 32'd2},          1'b0, '0},
    // unsorted tail on term 0
    '{'{CMD_APPEND, 3'd0, 32'd5},          1'b0, '0},
    '{'{CMD_RUN,    3'd0, 32'd0},          1'b0, '0},
    '{'{CMD_READ,   3'd0, 32'd256},        1'b0, '0},
    '{'{CMD_RSVD_A, 3'd0, 32'd0},          1'b0, '0},
    '{'{CMD_RSVD_B, 3'd7, 32'hFFFF_FFFF},  1'b0, '0},
    '{'{CMD_RSVD_C, 3'd2, 32'd1},          1'b0, '0},
    '{'{CMD_CLEAR,  3'd0, 32'd0},          1'b1, '{ST_OK, 9'd0, 32'd0}},
    '{'{CMD_RUN,    3'd0, 32'd0},          1'b1, '{ST_OK, 9'd0, 32'd0}},
    '{'{CMD_READ,   3'd0, 32'd0},          1'b1, '{ST_BAD_INDEX, 9'd0, 32'd0}}
  };

  phrase_position_intersect u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  // Cursor of term t moved past entries aligned below floor_v or not aligned at all
  function automatic int unsigned skip_to(int unsigned t, int unsigned cur,
                                          logic [31:0] floor_v);
    while (cur < list_len[t] &&
           !(pos_list[t][cur] >= term_off[t] &&
             pos_list[t][cur] - term_off[t] >= floor_v))
      cur++;
    return cur;
  endfunction

  // Leapfrog walk over the active terms; returns 1 when a match was dropped
  function automatic bit run_phrase_search();
    int unsigned cur [MAX_TERMS];
    int unsigned k;
    int unsigned i;
    bit          dropped;
    bit          done;
    bit          ahead;
    logic [31:0] pos;
    logic [31:0] nxt;
    logic [31:0] a;
    k = term_cnt_reg;
    if (k == 0) k = 1;
    if (k > MAX_TERMS) k = MAX_TERMS;
    foreach (cur[t]) cur[t] = 0;
    found_cnt = 0;
    dropped = 1'b0;
    done = 1'b0;
    while (!done) begin
      ahead = 1'b0;
      nxt = '0;
      cur[0] = skip_to(0, cur[0], '0);
      if (cur[0] >= list_len[0]) begin
        done = 1'b1;
      end else begin
        pos = pos_list[0][cur[0]] - term_off[0];
        for (i = 1; i < k && !done; i++) begin
          cur[i] = skip_to(i, cur[i], pos);
          if (cur[i] >= list_len[i]) begin
            done = 1'b1;
          end else begin
            a = pos_list[i][cur[i]] - term_off[i];
            if (a > pos && (!ahead || a > nxt)) begin
              nxt = a;
              ahead = 1'b1;
            end
          end
        end
        if (!done) begin
          if (ahead) begin
            cur[0] = skip_to(0, cur[0], nxt);
          end else begin
            if (found_cnt < MATCH_DEPTH) begin
              found_starts[found_cnt] = pos;
              found_cnt++;
            end else begin
              dropped = 1'b1;
            end
            cur[0]++;
          end
        end
      end
    end
    return dropped;
  endfunction

  // Applies one item to the predictor state and returns the result it causes
  function automatic out_item_t predict_response(in_item_t it);
    out_item_t r;
    r.status = ST_OK;
    r.read_value = '0;
    case (it.command)
      CMD_CLEAR: begin
        foreach (list_len[t]) begin
          list_len[t] = 0;
          term_off[t] = '0;
        end
        found_cnt = 0;
      end
      CMD_APPEND: begin
        if (int'(it.term) >= MAX_TERMS || list_len[it.term] >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos_list[it.term][list_len[it.term]] = it.value;
          list_len[it.term]++;
        end
      end
      CMD_OFFSET: begin
        if (int'(it.term) < MAX_TERMS) term_off[it.term] = it.value;
      end
      CMD_RUN: begin
        r.status = run_phrase_search() ? ST_FULL : ST_OK;
      end
      CMD_READ: begin
        if (it.value < found_cnt && it.value < MATCH_DEPTH)
          r.read_value = found_starts[it.value];
        else
          r.status = ST_BAD_INDEX;
      end
      default: ;
    endcase
    r.match_count = 9'(found_cnt);
    return r;
  endfunction

  function automatic in_item_t make_item(logic [2:0] cmd, int unsigned t,
                                         logic [31:0] v);
    in_item_t it;
    it.command = cmd;
    it.term = 3'(t);
    it.value = v;
    return it;
  endfunction

  // Small words half the time, with the extremes and full-width values mixed in
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  // Drives one item from a falling edge and waits for it to be taken
  task automatic send_item(input in_item_t it, input bit fixed = 1'b0,
                           input out_item_t fixed_result = '0);
    out_item_t pred;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_response(it);
    pending_results = {pending_results, (fixed ? fixed_result : pred)};
    if (it.command <= CMD_READ) items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_term_count(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    term_cnt_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fills term 0 one past its depth, then runs a single-term search that
  // fills the match store completely
  task automatic fill_stores();
    send_item(make_item(CMD_CLEAR, 0, '0));
    for (int i = 0; i <= LIST_DEPTH; i++)
      send_item(make_item(CMD_APPEND, 0, 32'(i * 5 + 1)));
    send_item(make_item(CMD_RUN, 0, '0));
    send_item(make_item(CMD_READ, 0, 32'(MATCH_DEPTH - 1)));
    send_item(make_item(CMD_READ, 0, 32'(MATCH_DEPTH)));
    send_item(make_item(CMD_READ, 0, '0));
  endtask

  // A phrase load: shared starts shifted by each term's offset plus noise,
  // then a run and a few reads
  task automatic phrase_sequence();
    logic [31:0] offs [MAX_TERMS];
    logic [31:0] starts [$];
    logic [31:0] plist [$];
    logic [31:0] s;
    logic [31:0] tmp;
    logic [31:0] w;
    int unsigned k_eff;
    int unsigned nterms;
    int unsigned j;
    int unsigned idx;
    k_eff = term_cnt_reg;
    if (k_eff == 0) k_eff = 1;
    if (k_eff > MAX_TERMS) k_eff = MAX_TERMS;
    nterms = k_eff;
    if ($urandom_range(0, 3) == 0) nterms = $urandom_range(k_eff, MAX_TERMS);
    send_item(make_item(CMD_CLEAR, 0, '0));

    s = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
    repeat ($urandom_range(1, 6)) begin
      s = s + $urandom_range(1, 8);
      starts = {starts, s};
    end

    for (int unsigned t = 0; t < nterms; t++) begin
      case ($urandom_range(0, 7))
        0: offs[t] = $urandom;
        1, 2: offs[t] = '0;
        default: offs[t] = t + $urandom_range(0, 3);
      endcase
      if (offs[t] != '0 || $urandom_range(0, 1))
        send_item(make_item(CMD_OFFSET, t, offs[t]));
      plist.delete();
      foreach (starts[i]) begin
        if ($urandom_range(0, 9) != 0) begin
          w = starts[i] + offs[t];
          plist = {plist, w};
        end
      end
      repeat ($urandom_range(0, 3)) begin
        if (offs[t] != '0 && $urandom_range(0, 2) == 0)
          w = $urandom_range(0, 32'(offs[t]) - 1);
        else
          w = starts[0] + offs[t] + $urandom_range(0, 60);
        plist = {plist, w};
      end
      plist.sort();
      // now and then a list out of order
      if (plist.size() > 1 && $urandom_range(0, 9) == 0) begin
        j = $urandom_range(0, plist.size() - 1);
        idx = $urandom_range(0, plist.size() - 1);
        tmp = plist[j];
        plist[j] = plist[idx];
        plist[idx] = tmp;
      end
      foreach (plist[i]) send_item(make_item(CMD_APPEND, t, plist[i]));
    end

    send_item(make_item(CMD_RUN, 0, '0));
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0)
        send_item(make_item(CMD_READ, 0, $urandom));
      else
        send_item(make_item(CMD_READ, 0, $urandom_range(0, found_cnt + 1)));
    end
  endtask

  task automatic noise_item();
    int unsigned pick;
    logic [2:0]  cmd;
    pick = $urandom_range(0, 19);
    if (pick == 0) cmd = CMD_CLEAR;
    else if (pick <= 6) cmd = CMD_APPEND;
    else if (pick <= 9) cmd = CMD_OFFSET;
    else if (pick <= 12) cmd = CMD_RUN;
    else if (pick <= 17) cmd = CMD_READ;
    else cmd = 3'($urandom_range(CMD_RSVD_C, CMD_RSVD_A));
    send_item(make_item(cmd, $urandom_range(0, MAX_TERMS - 1), rand_word()));
  endtask

  // One setting of term count and sender idling, run up to an item target
  task automatic run_phase(input logic [3:0] tc, input int idle,
                           input int target, input bit with_fill);
    wait_drained();
    write_term_count(tc);
    idle_pct = idle;
    if (with_fill) fill_stores();
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) phrase_sequence();
      else noise_item();
    end
  endtask

  // Result checker: each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d count=%0d value=%h",
                 $time, out_item.status, out_item.match_count, out_item.read_value);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.status !== oldest_result.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest_result.status, out_item.status);
          mismatches++;
        end
        if (out_item.match_count !== oldest_result.match_count) begin
          $display("%0t: match_count expected %0d actual %0d",
                   $time, oldest_result.match_count, out_item.match_count);
          mismatches++;
        end
        if (out_item.read_value !== oldest_result.read_value) begin
          $display("%0t: read_value expected %h actual %h",
                   $time, oldest_result.read_value, out_item.read_value);
          mismatches++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    foreach (list_len[t]) begin
      list_len[t] = 0;
      term_off[t] = '0;
    end
    found_cnt = 0;
    term_cnt_reg = TERM_COUNT_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed items at the reset term count
    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].fixed_result);

    // random phases; zero and fifteen exercise the term count clamps
    run_phase(4'd1, 0, 420, 1'b1);
    run_phase(4'd8, 64, 760, 1'b0);
    run_phase(4'd0, 6, 1100, 1'b0);
    run_phase(4'd15, 0, 1400, 1'b0);
    run_phase(4'd3, 64, 1650, 1'b0);
    run_phase(4'($urandom_range(4, 14)), 6, 1850, 1'b0);

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("phrase_position_intersect verification clean");
    else
      $display("phrase_position_intersect verification failed");
    $finish;
  end

  // Run limit
  initial begin
    #40ms;
    $display("phrase_position_intersect verification failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/ppi_pkg.sv
rtl/ppi_ram.sv
rtl/ppi_ctrl.sv
rtl/phrase_position_intersect.sv
bench/testbench.sv
